/* sv/bec_pkg.sv */
package bec_pkg;

    localparam int ROW_W    = 64;
    localparam int IDX_W    = 12;
    localparam int RCNT_W   = 13;
    localparam int CCNT_W   = 7;
    localparam int CFG_AW   = 1;
    localparam int MAX_COLS = 64;
    localparam int QDEPTH   = 4;
    localparam int MDATA_W  = 80;

    localparam logic [CFG_AW-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_AW-1:0] REG_COL_COUNT = 1'b1;

    localparam logic [RCNT_W-1:0] ROW_COUNT_RST = 13'd2;
    localparam logic [CCNT_W-1:0] COL_COUNT_RST = 7'd64;

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        row_t mask;
        row_t top_bit;
    } col_cfg_t;

    typedef struct packed {
        row_t             r_up;
        row_t             r_mid;
        row_t             r_dn;
        logic [IDX_W-1:0] idx;
        logic             fin;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic second_pending;
    } back_stat_t;

    function automatic row_t erode(input row_t c, input row_t u, input row_t d,
                                   input col_cfg_t cc);
        row_t left;
        row_t right;
        left  = (c << 1) | row_t'(1);
        right = (c >> 1) | cc.top_bit;
        return c & u & d & left & right & cc.mask;
    endfunction

endpackage

/* sv/bec_front.sv */
module bec_front import bec_pkg::*; #(
    parameter int RW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  row_t          s_tdata,
    input  col_cfg_t      col_cfg,
    input  logic [RW:0]   rows_eff,
    output logic          push,
    output job_t          job
);

    row_t          prev_row_reg, prev_row_next;
    row_t          prev_prev_row_reg, prev_prev_row_next;
    logic [RW-1:0] rows_seen_reg, rows_seen_next;
    row_t          cur;
    logic          accept;

    always_comb begin
        cur       = s_tdata & col_cfg.mask;
        accept    = s_tvalid & s_tready;
        job.r_up  = (rows_seen_reg == RW'(1)) ? '1 : prev_prev_row_reg;
        job.r_mid = prev_row_reg;
        job.r_dn  = cur;
        job.idx   = IDX_W'(rows_seen_reg - RW'(1));
        job.fin   = ({1'b0, rows_seen_reg} + (RW+1)'(1)) >= rows_eff;
        push      = accept && (rows_seen_reg != '0);

        prev_row_next      = prev_row_reg;
        prev_prev_row_next = prev_prev_row_reg;
        rows_seen_next     = rows_seen_reg;
        if (accept) begin
            if (rows_seen_reg == '0) begin
                prev_row_next      = cur;
                prev_prev_row_next = '0;
                rows_seen_next     = RW'(1);
            end else if (job.fin) begin
                prev_row_next      = '0;
                prev_prev_row_next = '0;
                rows_seen_next     = '0;
            end else begin
                prev_row_next      = cur;
                prev_prev_row_next = prev_row_reg;
                rows_seen_next     = rows_seen_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_row_reg      <= '0;
            prev_prev_row_reg <= '0;
            rows_seen_reg     <= '0;
        end else begin
            prev_row_reg      <= prev_row_next;
            prev_prev_row_reg <= prev_prev_row_next;
            rows_seen_reg     <= rows_seen_next;
        end
    end

endmodule

/* sv/bec_fifo.sv */
module bec_fifo import bec_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    wr_job,
    input  logic    pop,
    output job_t    rd_job,
    output q_stat_t stat
);

    localparam int PW = $clog2(QDEPTH);

    job_t          mem [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    always_comb begin
        stat.full  = (count_reg == (PW+1)'(QDEPTH));
        stat.empty = (count_reg == '0);
        rd_job     = mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + (PW+1)'(1);
                2'b01:   count_reg <= count_reg - (PW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* sv/bec_back.sv */
module bec_back import bec_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  job_t               head,
    input  logic               head_valid,
    input  col_cfg_t           col_cfg,
    output logic               pop,
    output back_stat_t         stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    typedef enum logic {PH_FIRST, PH_SECOND} phase_t;

    phase_t           phase_reg, phase_next;
    logic             valid_reg, valid_next;
    row_t             row_reg, row_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last_reg, last_next;
    logic             load;

    always_comb begin
        load       = head_valid && (!valid_reg || m_tready);
        pop        = 1'b0;
        phase_next = phase_reg;
        valid_next = valid_reg && !m_tready;
        row_next   = row_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            case (phase_reg)
                PH_FIRST: begin
                    row_next  = erode(head.r_mid, head.r_up, head.r_dn, col_cfg);
                    idx_next  = head.idx;
                    last_next = 1'b0;
                    if (head.fin) begin
                        phase_next = PH_SECOND;
                    end else begin
                        pop = 1'b1;
                    end
                end
                PH_SECOND: begin
                    row_next   = erode(head.r_dn, head.r_mid, '1, col_cfg);
                    idx_next   = head.idx + IDX_W'(1);
                    last_next  = 1'b1;
                    phase_next = PH_FIRST;
                    pop        = 1'b1;
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        row_reg  <= row_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    assign stat.second_pending = (phase_reg == PH_SECOND);
    assign m_tvalid = valid_reg;
    assign m_tdata  = MDATA_W'({idx_reg, row_reg});
    assign m_tlast  = last_reg;

endmodule

/* sv/binary_erosion_cross_top.sv */
// Binary erosion of a bitmap with a 4-neighbor cross, streamed one 64-bit row word per beat
// (bit j is column j, 1 is black). Eroded row r leaves when row r+1 has been taken; the beat
// that completes a frame yields two result beats, the row before it and the final row with
// tlast set. The input side takes one row per cycle while the four-entry queue is not full;
// the back end drains one result per cycle when not stalled. The queue between the
// row-tracking front end and the eroding output stage absorbs the extra beat at each frame
// end. A result beat passes the queue, then the output register; the final row follows
// once the output takes the beat before it. The user must write row_count (index 0) and
// col_count (index 1) only while the block is idle, which it does not enforce; out-of-range
// values are saturated, and column bits at or above the saturated col_count read as zero.
module binary_erosion_cross_top import bec_pkg::*; #(
    parameter int MAX_ROWS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [RCNT_W-1:0]  cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [ROW_W-1:0]   s_tdata,   // [63:0] in_row
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,   // [63:0] out_row, [75:64] out_index, zero above
    output logic               m_tlast    // frame_last
);

    localparam int RW = $clog2(MAX_ROWS);

    logic [RCNT_W-1:0] row_count_reg;
    logic [CCNT_W-1:0] col_count_reg;
    logic [RW:0]       rows_eff;
    logic [CCNT_W-1:0] cols_eff;
    col_cfg_t          col_cfg;
    logic              push;
    logic              pop;
    job_t              wr_job;
    job_t              head;
    q_stat_t           q_stat;
    back_stat_t        b_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ROW_COUNT: row_count_reg <= cfg_wdata;
                REG_COL_COUNT: col_count_reg <= cfg_wdata[CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (row_count_reg < RCNT_W'(2)) begin
            rows_eff = (RW+1)'(2);
        end else if (32'(row_count_reg) > MAX_ROWS) begin
            rows_eff = (RW+1)'(MAX_ROWS);
        end else begin
            rows_eff = (RW+1)'(row_count_reg);
        end

        if (col_count_reg < CCNT_W'(2)) begin
            cols_eff = CCNT_W'(2);
        end else if (col_count_reg > CCNT_W'(MAX_COLS)) begin
            cols_eff = CCNT_W'(MAX_COLS);
        end else begin
            cols_eff = col_count_reg;
        end

        col_cfg.mask    = (cols_eff >= CCNT_W'(ROW_W)) ? '1
                        : ((row_t'(1) << cols_eff) - row_t'(1));
        col_cfg.top_bit = row_t'(1) << (cols_eff - CCNT_W'(1));
    end

    assign s_tready = !q_stat.full;

    bec_front #(.RW(RW)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .col_cfg  (col_cfg),
        .rows_eff (rows_eff),
        .push     (push),
        .job      (wr_job)
    );

    bec_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_job  (wr_job),
        .pop     (pop),
        .rd_job  (head),
        .stat    (q_stat)
    );

    bec_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!q_stat.empty),
        .col_cfg    (col_cfg),
        .pop        (pop),
        .stat       (b_stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_second_after_first: assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.second_pending |-> (m_tvalid && !m_tlast))
        else $error("final row pending without a held non-final beat");

    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full && !pop |=> q_stat.full)
        else $error("queue level dropped without a pop");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

/* tb/sv/bec_erosion_checker.sv */
module bec_erosion_checker import bec_pkg::*; #(
    parameter int MAX_ROWS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [RCNT_W-1:0]  cfg_wdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [ROW_W-1:0]   s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [MDATA_W-1:0] m_tdata,
    input  logic               m_tlast,
    output int                 fail_count,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        row_t             pixels;
        logic [IDX_W-1:0] index;
        logic             last;
    } eroded_row_t;

    eroded_row_t       eroded_rows_due[$];
    logic [RCNT_W-1:0] height_reg;
    logic [CCNT_W-1:0] width_reg;
    row_t              newest_row;
    row_t              older_row;
    int                rows_in_frame;
    int                errors = 0;

    assign fail_count = errors;

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic row_t width_mask(input int cols);
        if (cols >= ROW_W) return '1;
        return (row_t'(1) << cols) - row_t'(1);
    endfunction

    // up and down are the vertical neighbors; missing rows count as all black
    function automatic row_t shrink_row(input row_t mid, input row_t up, input row_t down,
                                        input int cols);
        row_t m;
        row_t c;
        row_t west;
        row_t east;
        m = width_mask(cols);
        c = mid & m;
        west = {c[ROW_W-2:0], 1'b1};
        east = c >> 1;
        east[cols-1] = 1'b1;
        return c & up & down & west & east & m;
    endfunction

    task automatic take_row(input row_t raw);
        int          cols;
        int          rows;
        row_t        cur;
        eroded_row_t e;
        cols = clamp(int'(width_reg), 2, MAX_COLS);
        rows = clamp(int'(height_reg), 2, MAX_ROWS);
        cur = raw & width_mask(cols);
        if (rows_in_frame == 0) begin
            older_row = '0;
            newest_row = cur;
            rows_in_frame = 1;
            return;
        end
        e.pixels = shrink_row(newest_row, (rows_in_frame >= 2) ? older_row : '1, cur, cols);
        e.index = IDX_W'(rows_in_frame - 1);
        e.last = 1'b0;
        eroded_rows_due.push_back(e);
        if (rows_in_frame + 1 >= rows) begin
            e.pixels = shrink_row(cur, newest_row, '1, cols);
            e.index = IDX_W'(rows_in_frame);
            e.last = 1'b1;
            eroded_rows_due.push_back(e);
            newest_row = '0;
            older_row = '0;
            rows_in_frame = 0;
        end else begin
            older_row = newest_row;
            newest_row = cur;
            rows_in_frame++;
        end
    endtask

    always @(posedge aclk) begin
        eroded_row_t e;
        if (!aresetn) begin
            height_reg = ROW_COUNT_RST;
            width_reg = COL_COUNT_RST;
            newest_row = '0;
            older_row = '0;
            rows_in_frame = 0;
            eroded_rows_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ROW_COUNT: height_reg = cfg_wdata;
                    REG_COL_COUNT: width_reg = cfg_wdata[CCNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (eroded_rows_due.size() == 0) begin
                    $error("result beat with no row expected: out_row %h", m_tdata[ROW_W-1:0]);
                    errors++;
                end else begin
                    e = eroded_rows_due.pop_front();
                    if (m_tdata[ROW_W-1:0] !== e.pixels) begin
                        $error("out_row: expected %h, got %h", e.pixels, m_tdata[ROW_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[ROW_W +: IDX_W] !== e.index) begin
                        $error("out_index: expected %0d, got %0d", e.index,
                               m_tdata[ROW_W +: IDX_W]);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("frame_last: expected %b, got %b", e.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) take_row(s_tdata);
        end
        outstanding <= eroded_rows_due.size();
    end

endmodule

/* tb/sv/tb_binary_erosion_cross_top.sv */
module tb_binary_erosion_cross_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bec_pkg::*;

    localparam int MAX_ROWS    = 4096;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 16;
    localparam int RANDOM_ROWS = 800;
    localparam int CALM_TAIL   = 120;

    typedef enum int {PIX_NOISE, PIX_MOSTLY_BLACK, PIX_BLACK, PIX_ONE_HOLE} pix_style_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]  cfg_addr = '0;
    logic [RCNT_W-1:0]  cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    row_t               s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [MDATA_W-1:0] m_tdata;
    logic               m_tlast;

    int fail_count;
    int outstanding;
    bit calm = 1'b0;
    int sent = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    always #5 aclk = ~aclk;

    binary_erosion_cross_top #(.MAX_ROWS(MAX_ROWS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    bec_erosion_checker #(.MAX_ROWS(MAX_ROWS)) u_check (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always @(posedge aclk) begin
        if (calm || !aresetn) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(1, 17) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_row(input row_t r);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= r;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // hold input, wait for every expected row, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [RCNT_W-1:0] v);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic row_t pick_row(input pix_style_t style);
        row_t r;
        case (style)
            PIX_NOISE: r = {$urandom, $urandom};
            PIX_MOSTLY_BLACK: r = ~({$urandom, $urandom} & {$urandom, $urandom}
                                    & {$urandom, $urandom});
            PIX_BLACK: r = '1;
            default: begin
                r = '1;
                r[$urandom_range(0, ROW_W-1)] = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic send_rows(input int n, input pix_style_t style);
        for (int i = 0; i < n; i++) push_row(pick_row(style));
    endtask

    initial begin
        int         goal;
        int         kind;
        int         height;
        int         width;
        int         len;
        pix_style_t style;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        push_row('1);
        push_row('1);
        push_row('0);
        push_row('0);
        push_row('1);
        push_row(~row_t'(1));
        push_row(~(row_t'(1) << (ROW_W - 1)));
        push_row('1);
        push_row({32{2'b10}});
        push_row({32{2'b01}});

        write_reg(REG_ROW_COUNT, 13'd3);
        write_reg(REG_COL_COUNT, 13'd2);
        push_row('1);
        push_row('1);
        push_row('1);
        push_row('1);
        push_row(~row_t'(2));
        push_row('1);

        write_reg(REG_ROW_COUNT, 13'd0);
        write_reg(REG_COL_COUNT, 13'd0);
        push_row('1);
        push_row(row_t'(3));

        write_reg(REG_COL_COUNT, 13'h1FFF);
        write_reg(REG_ROW_COUNT, 13'd10);
        send_rows(4, PIX_MOSTLY_BLACK);
        write_reg(REG_ROW_COUNT, 13'd3);
        push_row(pick_row(PIX_ONE_HOLE));
        write_reg(REG_ROW_COUNT, 13'd5);
        send_rows(2, PIX_MOSTLY_BLACK);
        write_reg(REG_COL_COUNT, 13'd17);
        send_rows(3, PIX_MOSTLY_BLACK);

        write_reg(REG_COL_COUNT, 13'd64);
        write_reg(REG_ROW_COUNT, 13'h1FFF);
        send_rows(40, PIX_MOSTLY_BLACK);

        goal = sent + RANDOM_ROWS;
        while (sent < goal) begin
            kind = $urandom_range(0, 19);
            case (kind)
                0: height = $urandom_range(0, 1);
                1: height = $urandom_range(65, 8191);
                2, 3, 4, 5: height = $urandom_range(13, 64);
                default: height = $urandom_range(2, 12);
            endcase
            kind = $urandom_range(0, 19);
            case (kind)
                0: width = $urandom_range(0, 1);
                1: width = $urandom_range(65, 127);
                2: width = 64;
                3: width = 2;
                default: width = $urandom_range(2, 64);
            endcase
            write_reg(REG_ROW_COUNT, RCNT_W'(height));
            write_reg(REG_COL_COUNT, {6'($urandom_range(0, 63)), 7'(width)});
            len = (height < 2) ? 2 : height;
            if (len > 64) len = $urandom_range(1, 40);
            for (int f = $urandom_range(1, 4); f > 0; f--) begin
                calm = (goal - sent) < CALM_TAIL;
                style = pix_style_t'($urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0) begin
                    send_rows($urandom_range(1, len), style);
                end else begin
                    send_rows(len, style);
                end
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
